FILE: hdl/frame_rotate_flip_mirror_defines.svh
// ----------------------------------------------------------------------------
// Frame transform assertion macros
// Shared concurrent assertion forms used by the frame transform modules.
// ----------------------------------------------------------------------------
`ifndef FRAME_ROTATE_FLIP_MIRROR_DEFINES_SVH
`define FRAME_ROTATE_FLIP_MIRROR_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define FRM_ASSERT_IMPLY(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("frame transform: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define FRM_ASSERT_NEXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("frame transform: next-cycle check failed");

`endif

FILE: hdl/frm_pkg.sv
// ----------------------------------------------------------------------------
// Frame transform package
// Codes, register indexes and shared types of the frame transform block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

   // Word operation codes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Transform modes.
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_ROT90   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VFLIP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HMIRROR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_IDENT   = 2'd3;

   // Register indexes (byte address divided by four).
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd2;

   // Field widths.
   localparam int PIXEL_W    = 32;
   localparam int SIZE_W     = 9;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   // Control that travels with each command word to the frame store.
   typedef struct packed {
      logic op;
      logic last;
   } frm_cmd_type;

endpackage

`default_nettype wire

FILE: hdl/frm_addr_gen.sv
// ----------------------------------------------------------------------------
// Frame transform address generator
// Tracks the load and drain positions and registers one store command per
// accepted word, with the load address mapped through the transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frame_rotate_flip_mirror_defines.svh"

module frm_addr_gen
   import frm_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        clear,
   input  wire logic                                        accept,
   input  wire logic                                        req_op,
   input  wire logic [PIXEL_W-1:0]                          req_pixel_in,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]              w,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]             h,
   input  wire logic [MODE_W-1:0]                           mode,
   input  wire logic                                        cmd_ready,
   output logic                                             cmd_valid,
   output frm_cmd_type                                      cmd,
   output logic [((MAX_WIDTH*MAX_HEIGHT > 1) ?
                  $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0]    cmd_addr,
   output logic [PIXEL_W-1:0]                               cmd_data
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PA    = (XW > YW) ? XW : YW;
   localparam int PB    = (WW > HW) ? WW : HW;
   localparam int PW    = PA + PB;
   localparam int SW    = PW + 1;

   // Load position in the source frame, drain position in the output frame.
   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic [PA-1:0] dx_ff;
   logic [PA-1:0] dy_ff;
   logic [AW-1:0] daddr_ff;
   logic          cmd_valid_ff;
   frm_cmd_type   cmd_ff;
   logic [AW-1:0] cmd_addr_ff;
   logic [PIXEL_W-1:0] cmd_data_ff;

   logic [YW-1:0] h_m1_y;
   logic [XW-1:0] w_m1_x;
   logic [PA-1:0] mul_a;
   logic [PB-1:0] mul_b;
   logic [PA-1:0] add_c;
   logic [PW-1:0] prod;
   logic [SW-1:0] sum;
   logic [AW-1:0] cmd_addr_in;
   logic [PB-1:0] ow;
   logic [PB-1:0] oh;
   logic          x_last;
   logic          y_last;
   logic          dx_last;
   logic          dy_last;
   logic          drain_last;

   // Mirrored coordinates; both stay inside the frame since x < w and y < h.
   assign h_m1_y = YW'(h - HW'(1) - HW'(y_ff));
   assign w_m1_x = XW'(w - WW'(1) - WW'(x_ff));

   // Store address of the load position as a * b + c for each mode.
   always_comb begin
      unique case (mode)
         MODE_ROT90: begin
            mul_a = PA'(x_ff);
            mul_b = PB'(h);
            add_c = PA'(h_m1_y);
         end
         MODE_VFLIP: begin
            mul_a = PA'(h_m1_y);
            mul_b = PB'(w);
            add_c = PA'(x_ff);
         end
         MODE_HMIRROR: begin
            mul_a = PA'(y_ff);
            mul_b = PB'(w);
            add_c = PA'(w_m1_x);
         end
         default: begin
            mul_a = PA'(y_ff);
            mul_b = PB'(w);
            add_c = PA'(x_ff);
         end
      endcase
   end

   assign prod = PW'(mul_a) * PW'(mul_b);
   assign sum  = SW'(prod) + SW'(add_c);

   // Output frame size: rotation swaps width and height.
   assign ow = (mode == MODE_ROT90) ? PB'(h) : PB'(w);
   assign oh = (mode == MODE_ROT90) ? PB'(w) : PB'(h);

   // Position wrap detection.
   assign x_last     = (WW'(x_ff) == w - WW'(1));
   assign y_last     = (HW'(y_ff) == h - HW'(1));
   assign dx_last    = (PB'(dx_ff) == ow - PB'(1));
   assign dy_last    = (PB'(dy_ff) == oh - PB'(1));
   assign drain_last = dx_last && dy_last;

   assign cmd_addr_in = (req_op == OP_LOAD) ? AW'(sum) : daddr_ff;

   // Position counters and command valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         daddr_ff     <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         if (clear) begin
            x_ff     <= '0;
            y_ff     <= '0;
            dx_ff    <= '0;
            dy_ff    <= '0;
            daddr_ff <= '0;
         end else if (accept) begin
            if (req_op == OP_LOAD) begin
               if (x_last) begin
                  x_ff <= '0;
                  y_ff <= y_last ? '0 : y_ff + YW'(1);
               end else begin
                  x_ff <= x_ff + XW'(1);
               end
            end else begin
               if (drain_last) begin
                  dx_ff    <= '0;
                  dy_ff    <= '0;
                  daddr_ff <= '0;
               end else begin
                  daddr_ff <= daddr_ff + AW'(1);
                  if (dx_last) begin
                     dx_ff <= '0;
                     dy_ff <= dy_ff + PA'(1);
                  end else begin
                     dx_ff <= dx_ff + PA'(1);
                  end
               end
            end
         end

         if (accept) begin
            cmd_valid_ff <= 1'b1;
         end else if (cmd_ready) begin
            cmd_valid_ff <= 1'b0;
         end
      end
   end

   // Command payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff.op   <= req_op;
         cmd_ff.last <= (req_op == OP_DRAIN) && drain_last;
         cmd_addr_ff <= cmd_addr_in;
         cmd_data_ff <= req_pixel_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;
   assign cmd_addr  = cmd_addr_ff;
   assign cmd_data  = cmd_data_ff;

   // Positions stay inside the frame, and the drain wraps after the last pixel.
   `FRM_ASSERT_IMPLY(a_load_in_frame, clock, reset, accept,
                     32'(x_ff) < 32'(w) && 32'(y_ff) < 32'(h))
   `FRM_ASSERT_IMPLY(a_drain_in_frame, clock, reset, accept,
                     32'(dx_ff) < 32'(ow) && 32'(dy_ff) < 32'(oh))
   `FRM_ASSERT_NEXT(a_drain_wraps, clock, reset,
                    accept && req_op == OP_DRAIN && drain_last && !clear, daddr_ff == '0)

endmodule

`default_nettype wire

FILE: hdl/frm_store.sv
// ----------------------------------------------------------------------------
// Frame transform store
// Single-port frame memory: load commands write it, drain commands read it
// into the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frame_rotate_flip_mirror_defines.svh"

module frm_store
   import frm_pkg::*;
#(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire frm_cmd_type        cmd,
   input  wire logic [AW-1:0]      cmd_addr,
   input  wire logic [PIXEL_W-1:0] cmd_data,
   output logic                    cmd_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                    rsp_frame_end
);

   logic [PIXEL_W-1:0] store_mem [DEPTH];
   logic [PIXEL_W-1:0] rd_ff;
   logic               last_ff;
   logic               rsp_vld_ff;
   logic               cmd_go;

   // A load never touches the output word; a drain needs the output word free or being taken.
   assign cmd_ready = (cmd.op == OP_LOAD) || !rsp_vld_ff || rsp_ready;
   assign cmd_go    = cmd_valid && cmd_ready;

   // Memory port: write on load, registered read on drain.
   always_ff @(posedge clock) begin
      if (cmd_go) begin
         if (cmd.op == OP_LOAD) begin
            store_mem[cmd_addr] <= cmd_data;
         end else begin
            rd_ff <= store_mem[cmd_addr];
         end
      end
   end

   // Frame end flag travels beside the read data.
   always_ff @(posedge clock) begin
      if (cmd_go && cmd.op == OP_DRAIN) begin
         last_ff <= cmd.last;
      end
   end

   // Output word valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd_go && cmd.op == OP_DRAIN) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_pixel_out = rd_ff;
   assign rsp_frame_end = last_ff;

   // Drains produce a word, loads leave a waiting word alone.
   `FRM_ASSERT_NEXT(a_drain_gives_word, clock, reset,
                    cmd_go && cmd.op == OP_DRAIN, rsp_vld_ff)
   `FRM_ASSERT_NEXT(a_load_keeps_word, clock, reset,
                    cmd_valid && cmd.op == OP_LOAD && rsp_vld_ff && !rsp_ready,
                    rsp_vld_ff && $stable(rd_ff) && $stable(last_ff))
   `FRM_ASSERT_IMPLY(a_word_has_source, clock, reset, $rose(rsp_vld_ff),
                     $past(cmd_valid && cmd_ready && cmd.op == OP_DRAIN))

endmodule

`default_nettype wire

FILE: hdl/frame_rotate_flip_mirror.sv
// ----------------------------------------------------------------------------
// Frame rotate / flip / mirror
// Loads a pixel frame in raster order into a frame store at transformed
// addresses and drains it back out in output raster order.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Word contents
//   req_     in         req_valid/ready    req_op, req_pixel_in
//   rsp_     out        rsp_valid/ready    rsp_pixel_out, rsp_frame_end
//   csr_     in         APB write/read     frame_width, frame_height, mode
//
// One word is accepted per cycle unless a drain stalls. A load is written
// to the store in the cycle after acceptance; a drain reads the single store
// port once the output word is free or taken, and its registered read offers
// the word on rsp_. Loads keep flowing while a drain word waits; a second
// drain waits behind it. Reset clears the positions and registers; the store
// contents are undefined until loaded, so no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_rotate_flip_mirror
   import frm_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [PIXEL_W-1:0]    req_pixel_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [PIXEL_W-1:0]         rsp_pixel_out,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [WW-1:0] W_RESET = WW'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
   localparam logic [HW-1:0] H_RESET = HW'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

   logic [SIZE_W-1:0]    width_ff;
   logic [SIZE_W-1:0]    height_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic [WW-1:0]        w_eff_ff;
   logic [HW-1:0]        h_eff_ff;
   logic [WW-1:0]        w_eff_in;
   logic [HW-1:0]        h_eff_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic [SIZE_W-1:0]    wdata_size;
   logic                 cfg_write;
   logic                 cfg_clear;
   logic                 accept;
   logic                 cmd_valid;
   logic                 cmd_ready;
   frm_cmd_type          cmd;
   logic [AW-1:0]        cmd_addr;
   logic [PIXEL_W-1:0]   cmd_data;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wdata_size = csr_pwdata[SIZE_W-1:0];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_clear  = cfg_write && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                                     reg_idx == REG_MODE);
   assign csr_pready = 1'b1;

   // Written sizes are clamped to the frame store limits.
   always_comb begin
      if (wdata_size == '0) begin
         w_eff_in = WW'(1);
      end else if (32'(wdata_size) > MAX_WIDTH) begin
         w_eff_in = WW'(MAX_WIDTH);
      end else begin
         w_eff_in = WW'(wdata_size);
      end

      if (wdata_size == '0) begin
         h_eff_in = HW'(1);
      end else if (32'(wdata_size) > MAX_HEIGHT) begin
         h_eff_in = HW'(MAX_HEIGHT);
      end else begin
         h_eff_in = HW'(wdata_size);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
         mode_ff   <= MODE_ROT90;
         w_eff_ff  <= W_RESET;
         h_eff_ff  <= H_RESET;
      end else if (cfg_write) begin
         unique case (reg_idx)
            REG_WIDTH: begin
               width_ff <= wdata_size;
               w_eff_ff <= w_eff_in;
            end
            REG_HEIGHT: begin
               height_ff <= wdata_size;
               h_eff_ff  <= h_eff_in;
            end
            REG_MODE: begin
               mode_ff <= csr_pwdata[MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // A new word enters when the command register is free or moving on.
   assign req_ready = !cmd_valid || cmd_ready;
   assign accept    = req_valid && req_ready;

   frm_addr_gen #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr_gen (
      .clock        (clock),
      .reset        (reset),
      .clear        (cfg_clear),
      .accept       (accept),
      .req_op       (req_op),
      .req_pixel_in (req_pixel_in),
      .w            (w_eff_ff),
      .h            (h_eff_ff),
      .mode         (mode_ff),
      .cmd_ready    (cmd_ready),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_addr     (cmd_addr),
      .cmd_data     (cmd_data)
   );

   frm_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_addr      (cmd_addr),
      .cmd_data      (cmd_data),
      .cmd_ready     (cmd_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rotate / flip / mirror testbench
// A queue of pixel words feeds a valid/ready driver. A clocked monitor
// predicts the frame store contents for every accepted word and checks each
// drained pixel and its frame end mark against the oldest prediction. Frame
// size and transform mode are set over the register port between phases.
// ----------------------------------------------------------------------------

module tb;
   import frm_pkg::*;

   localparam int STORE_WORDS   = 256 * 256;
   localparam int MAX_SIDE      = 256;
   localparam int TARGET_WORDS  = 1200;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int IDLE_PCT      = 12;
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef enum int {FULL_FRAMES, MIXED, BROKEN} phase_style_type;

   typedef struct packed {
      logic               op;
      logic [PIXEL_W-1:0] pixel;
   } src_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_end;
   } out_word_type;

   // Block ports.
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic                  req_op       = OP_LOAD;
   logic [PIXEL_W-1:0]    req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel_out;
   logic                  rsp_frame_end;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predicted block state.
   logic [SIZE_W-1:0]  width_reg  = SIZE_RESET;
   logic [SIZE_W-1:0]  height_reg = SIZE_RESET;
   logic [MODE_W-1:0]  mode_reg   = MODE_ROT90;
   logic [PIXEL_W-1:0] model_store [STORE_WORDS];
   int unsigned        model_load  = 0;
   int unsigned        model_drain = 0;

   // Stimulus side view of the store: which entries have been loaded.
   bit                 gen_written [STORE_WORDS];
   int unsigned        gen_load  = 0;
   int unsigned        gen_drain = 0;

   src_word_type src_words[$];
   out_word_type expected_pixels[$];
   logic         req_fire    = 1'b0;
   int           err_count   = 0;
   int           cycle_count = 0;
   int           queued_words = 0;

   frame_rotate_flip_mirror i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_pixel_in (req_pixel_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_frame_end(rsp_frame_end),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A size of zero counts as one and anything above the store side is capped.
   function automatic int unsigned side_len(input logic [SIZE_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return 32'(v);
   endfunction

   // Store address of a source raster position under the given transform.
   function automatic int unsigned store_addr(input int unsigned idx, input int unsigned w,
                                              input int unsigned h,
                                              input logic [MODE_W-1:0] mode);
      int unsigned x, y;
      x = idx % w;
      y = idx / w;
      unique case (mode)
         MODE_ROT90:   return x * h + (h - 1 - y);
         MODE_VFLIP:   return (h - 1 - y) * w + x;
         MODE_HMIRROR: return y * w + (w - 1 - x);
         default:      return y * w + x;
      endcase
   endfunction

   function automatic int unsigned frame_words();
      return side_len(width_reg) * side_len(height_reg);
   endfunction

   // Updates the predicted store for one accepted word and queues the pixel
   // that a drain word must return.
   function automatic void transform_word(input logic op, input logic [PIXEL_W-1:0] pixel);
      int unsigned  n;
      out_word_type o;
      n = frame_words();
      if (op == OP_LOAD) begin
         if (model_load >= n) model_load = 0;
         model_store[store_addr(model_load, side_len(width_reg), side_len(height_reg),
                                mode_reg)] = pixel;
         model_load = (model_load + 1 >= n) ? 0 : model_load + 1;
      end else begin
         if (model_drain >= n) model_drain = 0;
         o.pixel     = model_store[model_drain];
         o.frame_end = (model_drain == n - 1);
         expected_pixels.push_back(o);
         model_drain = (model_drain + 1 >= n) ? 0 : model_drain + 1;
      end
   endfunction

   // A drain is only issued when the entry it reads has been loaded.
   function automatic bit drain_ok();
      return gen_written[gen_drain];
   endfunction

   function automatic void queue_word(input logic op, input logic [PIXEL_W-1:0] pixel);
      int unsigned  n;
      src_word_type s;
      n = frame_words();
      if (op == OP_LOAD) begin
         gen_written[store_addr(gen_load, side_len(width_reg), side_len(height_reg),
                                mode_reg)] = 1'b1;
         gen_load = (gen_load + 1 >= n) ? 0 : gen_load + 1;
      end else begin
         gen_drain = (gen_drain + 1 >= n) ? 0 : gen_drain + 1;
      end
      s.op    = op;
      s.pixel = pixel;
      src_words.push_back(s);
      queued_words++;
   endfunction

   // Random idle cycles, with a quiet stretch in every window.
   function automatic bit idle_roll();
      if ((cycle_count % 3000) < 500) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   // Waits until every word is accepted and answered, then lets the store settle.
   task automatic settle();
      while (src_words.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register while the block is idle, then reads back any real register.
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      settle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      unique case (idx)
         REG_WIDTH:  width_reg  = value[SIZE_W-1:0];
         REG_HEIGHT: height_reg = value[SIZE_W-1:0];
         REG_MODE:   mode_reg   = value[MODE_W-1:0];
         default: ;
      endcase
      if (idx == REG_SPARE) begin
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end else begin
         // Any real register write restarts both raster positions.
         model_load  = 0;
         model_drain = 0;
         gen_load    = 0;
         gen_drain   = 0;
         @(negedge clock);
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         unique case (idx)
            REG_WIDTH:  want = CSR_DATA_W'(width_reg);
            REG_HEIGHT: want = CSR_DATA_W'(height_reg);
            default:    want = CSR_DATA_W'(mode_reg);
         endcase
         if (csr_prdata !== want) begin
            $error("csr_prdata: expected %h, actual %h", want, csr_prdata);
            err_count++;
         end
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // One phase: set size and mode, then load and drain in the given style.
   // The phase queues no more than cap words; frames too large for
   // that are exercised with a mixed stream instead of whole frames.
   task automatic run_phase(input logic [SIZE_W-1:0] wv, input logic [SIZE_W-1:0] hv,
                            input logic [MODE_W-1:0] mv, input phase_style_type style,
                            input int cap);
      int unsigned n, count, k, frames;
      write_reg(REG_WIDTH, ($urandom() & ~32'h1FF) | CSR_DATA_W'(wv));
      write_reg(REG_HEIGHT, ($urandom() & ~32'h1FF) | CSR_DATA_W'(hv));
      write_reg(REG_MODE, ($urandom() & ~32'h3) | CSR_DATA_W'(mv));
      n = frame_words();
      if (style == FULL_FRAMES && 2 * n > cap) style = MIXED;
      unique case (style)
         FULL_FRAMES: begin
            frames = (4 * n <= cap) ? $urandom_range(1, 2) : 1;
            repeat (frames) begin
               repeat (n) queue_word(OP_LOAD, $urandom());
               if ($urandom_range(9) == 0) write_reg(REG_SPARE, $urandom());
               repeat (n) queue_word(OP_DRAIN, $urandom());
            end
         end
         MIXED: begin
            count = $urandom_range(1, 3 * n);
            if (count > cap) count = cap;
            repeat (count) begin
               if ($urandom_range(1) && drain_ok()) queue_word(OP_DRAIN, $urandom());
               else queue_word(OP_LOAD, $urandom());
            end
         end
         default: begin
            // A frame cut short: drains go only as far as the loaded entries.
            k = $urandom_range(1, n);
            if (2 * k > cap) k = cap / 2;
            repeat (k) queue_word(OP_LOAD, $urandom());
            repeat (k) begin
               if (drain_ok()) queue_word(OP_DRAIN, $urandom());
            end
         end
      endcase
   endtask

   // Input driver: presents the next queued word once the current one is taken.
   always @(negedge clock) begin : drive_req
      src_word_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (src_words.size() != 0 && !idle_roll()) begin
            s = src_words.pop_front();
            req_valid    <= 1'b1;
            req_op       <= s.op;
            req_pixel_in <= s.pixel;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !idle_roll();
   end

   // Monitor: checks drained words and predicts accepted ones.
   always @(posedge clock) begin : watch
      out_word_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected word: pixel_out %h frame_end %b", rsp_pixel_out,
                      rsp_frame_end);
               err_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  $error("pixel_out: expected %h, actual %h", want.pixel, rsp_pixel_out);
                  err_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, actual %b", want.frame_end, rsp_frame_end);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) transform_word(req_op, req_pixel_in);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin : stimulus
      int                r;
      logic [SIZE_W-1:0] wv, hv, big, tiny;
      phase_style_type   style;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Loads under the reset size and mode.
      queue_word(OP_LOAD, 32'h0000_0000);
      queue_word(OP_LOAD, 32'hFFFF_FFFF);
      queue_word(OP_LOAD, $urandom());

      // 2x2 rotation; a write past the register list must not restart the frame.
      write_reg(REG_WIDTH, 32'hFFFF_FE02);
      write_reg(REG_HEIGHT, 32'd2);
      write_reg(REG_MODE, 32'hFFFF_FFFC | CSR_DATA_W'(MODE_ROT90));
      queue_word(OP_LOAD, 32'h0000_0000);
      queue_word(OP_LOAD, 32'hFFFF_FFFF);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      queue_word(OP_LOAD, 32'h1234_5678);
      queue_word(OP_LOAD, 32'h8765_4321);
      repeat (4) queue_word(OP_DRAIN, $urandom());

      // Second frame after the wrap, and a mode write that restarts draining.
      repeat (4) queue_word(OP_LOAD, $urandom());
      repeat (2) queue_word(OP_DRAIN, $urandom());
      write_reg(REG_MODE, CSR_DATA_W'(MODE_ROT90));
      repeat (2) queue_word(OP_DRAIN, $urandom());

      // Width of zero is taken as one.
      write_reg(REG_WIDTH, 32'h0000_0200);
      write_reg(REG_HEIGHT, 32'd3);
      write_reg(REG_MODE, CSR_DATA_W'(MODE_VFLIP));
      repeat (3) queue_word(OP_LOAD, $urandom());
      repeat (3) queue_word(OP_DRAIN, $urandom());

      // Largest sizes, including widths and heights above the store side.
      run_phase(9'd511, 9'd1, MODE_HMIRROR, FULL_FRAMES, 520);
      run_phase(9'd1, 9'd256, MODE_IDENT, FULL_FRAMES, 60);
      run_phase(9'd256, 9'd2, MODE_ROT90, FULL_FRAMES, 60);
      run_phase(9'd2, 9'd300, MODE_VFLIP, FULL_FRAMES, 60);
      run_phase(9'd256, 9'd256, MODE_IDENT, MIXED, 60);

      // Random phases, mostly small frames.
      while (queued_words < TARGET_WORDS) begin
         r = $urandom_range(99);
         if (r < 8) begin
            big  = $urandom_range(1) ? 9'd256 : SIZE_W'($urandom_range(257, 511));
            tiny = SIZE_W'($urandom_range(0, 2));
            if ($urandom_range(1)) begin
               wv = big;
               hv = tiny;
            end else begin
               wv = tiny;
               hv = big;
            end
         end else if (r < 30) begin
            wv = SIZE_W'($urandom_range(0, 16));
            hv = SIZE_W'($urandom_range(0, 16));
         end else begin
            wv = SIZE_W'($urandom_range(1, 6));
            hv = SIZE_W'($urandom_range(1, 6));
         end
         r = $urandom_range(99);
         style = (r < 60) ? FULL_FRAMES : (r < 80) ? MIXED : BROKEN;
         run_phase(wv, hv, MODE_W'($urandom_range(3)), style, 150);
      end

      settle();
      if (err_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

FILE: frame_rotate_flip_mirror.f
+incdir+hdl
hdl/frm_pkg.sv
hdl/frm_addr_gen.sv
hdl/frm_store.sv
hdl/frame_rotate_flip_mirror.sv
sim/tb.sv
